// File: hw/rtl/imabd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder package
// Shared types, register indexes and the IMA step table.
// ----------------------------------------------------------------------------
package imabd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SAMPLES     = 2'd1;

    localparam logic [15:0] SPB_RESET   = 16'd505;
    localparam logic [31:0] TOTAL_RESET = 32'hFFFF_FFFF;

    localparam logic [6:0] IDX_MAX = 7'd88;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       restart;
    } in_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               stream_end;
    } out_t;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_ONE    = 2'd1,
        CMD_TWO    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        clr;
        logic [15:0] value;
        logic [6:0]  index;
    } cmd_t;

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        begin
            unique case (idx)
                7'd0:  s = 15'd7;
                7'd1:  s = 15'd8;
                7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;
                7'd4:  s = 15'd11;
                7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;
                7'd7:  s = 15'd14;
                7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;
                7'd10: s = 15'd19;
                7'd11: s = 15'd21;
                7'd12: s = 15'd23;
                7'd13: s = 15'd25;
                7'd14: s = 15'd28;
                7'd15: s = 15'd31;
                7'd16: s = 15'd34;
                7'd17: s = 15'd37;
                7'd18: s = 15'd41;
                7'd19: s = 15'd45;
                7'd20: s = 15'd50;
                7'd21: s = 15'd55;
                7'd22: s = 15'd60;
                7'd23: s = 15'd66;
                7'd24: s = 15'd73;
                7'd25: s = 15'd80;
                7'd26: s = 15'd88;
                7'd27: s = 15'd97;
                7'd28: s = 15'd107;
                7'd29: s = 15'd118;
                7'd30: s = 15'd130;
                7'd31: s = 15'd143;
                7'd32: s = 15'd157;
                7'd33: s = 15'd173;
                7'd34: s = 15'd190;
                7'd35: s = 15'd209;
                7'd36: s = 15'd230;
                7'd37: s = 15'd253;
                7'd38: s = 15'd279;
                7'd39: s = 15'd307;
                7'd40: s = 15'd337;
                7'd41: s = 15'd371;
                7'd42: s = 15'd408;
                7'd43: s = 15'd449;
                7'd44: s = 15'd494;
                7'd45: s = 15'd544;
                7'd46: s = 15'd598;
                7'd47: s = 15'd658;
                7'd48: s = 15'd724;
                7'd49: s = 15'd796;
                7'd50: s = 15'd876;
                7'd51: s = 15'd963;
                7'd52: s = 15'd1060;
                7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;
                7'd55: s = 15'd1411;
                7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;
                7'd58: s = 15'd1878;
                7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;
                7'd61: s = 15'd2499;
                7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;
                7'd64: s = 15'd3327;
                7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;
                7'd67: s = 15'd4428;
                7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;
                7'd70: s = 15'd5894;
                7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;
                7'd73: s = 15'd7845;
                7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;
                7'd76: s = 15'd10442;
                7'd77: s = 15'd11487;
                7'd78: s = 15'd12635;
                7'd79: s = 15'd13899;
                7'd80: s = 15'd15289;
                7'd81: s = 15'd16818;
                7'd82: s = 15'd18500;
                7'd83: s = 15'd20350;
                7'd84: s = 15'd22385;
                7'd85: s = 15'd24623;
                7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/imabd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMA ADPCM front end
// Accepts stream bytes, parses block headers and turns each data byte and
// each complete header into a decode command for the back end.
// ----------------------------------------------------------------------------
module imabd_front
    import imabd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_t         in_data,
    input  wire logic        full,
    input  wire logic [15:0] samples_per_block,
    output logic             cmd_push,
    output cmd_t             cmd
);

    typedef enum logic [1:0] {
        PH_LOW   = 2'd0,
        PH_HIGH  = 2'd1,
        PH_INDEX = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [7:0]  low_reg, low_next;
    logic [15:0] pred_reg, pred_next;
    logic [6:0]  idx_reg, idx_next;
    logic [15:0] left_reg, left_next, left_cur;
    logic        clr_reg, clr_next, clr_cur;
    logic        take;
    logic [7:0]  b;

    always_comb
    begin
        take       = push && !full;
        b          = in_data.stream_byte;
        phase_next = phase_reg;
        low_next   = low_reg;
        pred_next  = pred_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        clr_next   = clr_reg;
        phase_cur  = in_data.restart ? PH_LOW : phase_reg;
        left_cur   = in_data.restart ? 16'd0 : left_reg;
        clr_cur    = in_data.restart || clr_reg;
        cmd_push   = 1'b0;
        cmd.kind   = CMD_HEADER;
        cmd.clr    = clr_cur;
        cmd.value  = pred_reg;
        cmd.index  = idx_reg;
        if (take)
        begin
            clr_next  = clr_cur;
            left_next = left_cur;
            if (left_cur == 16'd0)
            begin
                unique case (phase_cur)
                    PH_LOW:
                    begin
                        low_next   = b;
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        pred_next  = {b, low_reg};
                        phase_next = PH_INDEX;
                    end
                    PH_INDEX:
                    begin
                        if (b[7])
                        begin
                            idx_next = 7'd0;
                        end
                        else if (b[6:0] > IDX_MAX)
                        begin
                            idx_next = IDX_MAX;
                        end
                        else
                        begin
                            idx_next = b[6:0];
                        end
                        phase_next = PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        cmd_push   = 1'b1;
                        clr_next   = 1'b0;
                        phase_next = PH_LOW;
                        left_next  = (samples_per_block == 16'd0) ? 16'd0
                                                                  : samples_per_block - 16'd1;
                    end
                    default:
                    begin
                        phase_next = PH_LOW;
                    end
                endcase
            end
            else
            begin
                cmd_push  = 1'b1;
                clr_next  = 1'b0;
                cmd.value = {8'd0, b};
                if (left_cur == 16'd1)
                begin
                    cmd.kind  = CMD_ONE;
                    left_next = 16'd0;
                end
                else
                begin
                    cmd.kind  = CMD_TWO;
                    left_next = left_cur - 16'd2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOW;
            low_reg   <= 8'd0;
            pred_reg  <= 16'd0;
            idx_reg   <= 7'd0;
            left_reg  <= 16'd0;
            clr_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            low_reg   <= low_next;
            pred_reg  <= pred_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
            clr_reg   <= clr_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/imabd_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMA ADPCM command queue
// Two-entry queue that decouples the front end from the decode back end.
// ----------------------------------------------------------------------------
module imabd_cmd_queue
    import imabd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wr_data,
    input  wire logic rd,
    output logic      full,
    output logic      valid,
    output cmd_t      head
);

    cmd_t       entry_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    always_comb
    begin
        full       = (count_reg == 2'd2);
        valid      = (count_reg != 2'd0);
        head       = entry_reg[rptr_reg];
        do_wr      = wr && !full;
        do_rd      = rd && valid;
        count_next = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/imabd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMA ADPCM decode back end
// Executes header and nibble commands, one sample per cycle while a command
// waits and the output queue has room, and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module imabd_back
    import imabd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire cmd_t        cmd_head,
    output logic             cmd_pop,
    input  wire logic [31:0] total_samples,
    output logic             empty,
    input  wire logic        pop,
    output out_t             out_data
);

    logic signed [15:0] pred_reg, pred_next;
    logic [6:0]         idx_reg, idx_next;
    logic [31:0]        pos_reg, pos_next, pos_base;
    logic               sel_reg, sel_next;

    out_t       ob_reg [2];
    logic       ob_wptr_reg, ob_rptr_reg;
    logic [1:0] ob_count_reg, ob_count_next;
    logic       ob_pop, ob_space;

    logic [3:0]         nib;
    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [18:0] sum;
    logic signed [15:0] sat;
    logic signed [7:0]  idx_sum;
    logic [6:0]         idx_dec;
    logic               is_hdr, final_nib, fire;
    out_t               result;

    always_comb
    begin
        ob_pop   = pop && (ob_count_reg != 2'd0);
        ob_space = (ob_count_reg != 2'd2) || ob_pop;
        is_hdr   = (cmd_head.kind == CMD_HEADER);
        nib      = sel_reg ? cmd_head.value[7:4] : cmd_head.value[3:0];

        step = step_size(idx_reg);
        diff = {5'd0, step[14:3]};
        if (nib[0])
        begin
            diff = diff + {4'd0, step[14:2]};
        end
        if (nib[1])
        begin
            diff = diff + {3'd0, step[14:1]};
        end
        if (nib[2])
        begin
            diff = diff + {2'd0, step};
        end
        if (nib[3])
        begin
            sum = 19'(pred_reg) - $signed({2'b00, diff});
        end
        else
        begin
            sum = 19'(pred_reg) + $signed({2'b00, diff});
        end
        if (sum > 19'sd32767)
        begin
            sat = 16'sd32767;
        end
        else if (sum < -19'sd32768)
        begin
            sat = -16'sd32768;
        end
        else
        begin
            sat = sum[15:0];
        end

        case (nib[2:0])
            3'd4:    idx_sum = $signed({1'b0, idx_reg}) + 8'sd2;
            3'd5:    idx_sum = $signed({1'b0, idx_reg}) + 8'sd4;
            3'd6:    idx_sum = $signed({1'b0, idx_reg}) + 8'sd6;
            3'd7:    idx_sum = $signed({1'b0, idx_reg}) + 8'sd8;
            default: idx_sum = $signed({1'b0, idx_reg}) - 8'sd1;
        endcase
        if (idx_sum < 8'sd0)
        begin
            idx_dec = 7'd0;
        end
        else if (idx_sum > $signed({1'b0, IDX_MAX}))
        begin
            idx_dec = IDX_MAX;
        end
        else
        begin
            idx_dec = idx_sum[6:0];
        end

        pos_base = (cmd_head.clr && !sel_reg) ? 32'd0 : pos_reg;
        fire     = cmd_valid && ob_space;
        final_nib = is_hdr || (cmd_head.kind == CMD_ONE) || sel_reg;
        cmd_pop  = fire && final_nib;

        pred_next = pred_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        sel_next  = sel_reg;
        if (fire)
        begin
            pos_next  = (&pos_base) ? pos_base : pos_base + 32'd1;
            pred_next = is_hdr ? $signed(cmd_head.value) : sat;
            idx_next  = is_hdr ? cmd_head.index : idx_dec;
            sel_next  = !final_nib;
        end

        result.sample     = pred_next;
        result.last       = final_nib;
        result.stream_end = (pos_next >= total_samples);

        ob_count_next = ob_count_reg + {1'b0, fire} - {1'b0, ob_pop};
        empty         = (ob_count_reg == 2'd0);
        out_data      = ob_reg[ob_rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg     <= 16'sd0;
            idx_reg      <= 7'd0;
            pos_reg      <= 32'd0;
            sel_reg      <= 1'b0;
            ob_wptr_reg  <= 1'b0;
            ob_rptr_reg  <= 1'b0;
            ob_count_reg <= 2'd0;
        end
        else
        begin
            pred_reg     <= pred_next;
            idx_reg      <= idx_next;
            pos_reg      <= pos_next;
            sel_reg      <= sel_next;
            ob_count_reg <= ob_count_next;
            if (fire)
            begin
                ob_wptr_reg <= !ob_wptr_reg;
            end
            if (ob_pop)
            begin
                ob_rptr_reg <= !ob_rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ob_reg[ob_wptr_reg] <= result;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ima_adpcm_block_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder
// Mono 4-bit IMA ADPCM decoder for block-structured byte streams.
// ----------------------------------------------------------------------------
// Bytes are pushed one per transaction while full is low and are parsed by a
// front end that takes one byte every cycle while full is low. The decode unit
// produces one sample per cycle while its output queue has space, so a data
// byte that yields two samples occupies it for both samples before its command
// is popped. A two-entry command queue sits between the parser and the
// decoder, and a two-entry sample queue sits on the output, so input is taken
// while finished samples wait. A sample is registered in the command queue and
// then in the sample queue before it can be popped. Configuration writes are
// always ready and should only be issued while the decoder is idle.
// ----------------------------------------------------------------------------
module ima_adpcm_block_decoder
    import imabd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire in_t                  in_data,
    output logic                      empty,
    input  wire logic                 pop,
    output out_t                      out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic [15:0] spb_reg;
    logic [31:0] total_reg;
    logic        cmd_push, cmd_pop, cmd_valid;
    cmd_t        cmd, cmd_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg   <= SPB_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SAMPLES_PER_BLOCK: spb_reg   <= cfg_data[15:0];
                CFG_TOTAL_SAMPLES:     total_reg <= cfg_data;
                default:               spb_reg   <= spb_reg;
            endcase
        end
    end

    imabd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .in_data           (in_data),
        .full              (full),
        .samples_per_block (spb_reg),
        .cmd_push          (cmd_push),
        .cmd               (cmd)
    );

    imabd_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd),
        .rd      (cmd_pop),
        .full    (full),
        .valid   (cmd_valid),
        .head    (cmd_head)
    );

    imabd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_head      (cmd_head),
        .cmd_pop       (cmd_pop),
        .total_samples (total_reg),
        .empty         (empty),
        .pop           (pop),
        .out_data      (out_data)
    );

endmodule
`default_nettype wire
